// ===== hdl/b64d_pkg.sv =====
// Shared types, codes and the alphabet lookup for the streaming base64 decoder.
// No dependencies; used by every module under hdl/.

package b64d_pkg;

	// Reset value of the padding character register ('=')
	localparam logic [7:0] PAD_RESET = 8'h3d;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_MISPLACED   = 3'd2,
		ST_DATA_AFTER  = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_AFTER_GROUP = 3'd5
	} status_t;

	// Decoder stream state
	typedef struct packed {
		logic [1:0]  pos;     // index of next character within its group
		logic [17:0] gbits;   // sixtets gathered so far, newest lowest
		logic [1:0]  pads;    // padding characters seen in the group
		logic        pdone;   // a padded group has finished
		logic        failed;  // error reported, drop until end mark
	} dec_state_t;

	// Results caused by one character: up to three bytes
	typedef struct packed {
		logic        eos;     // final result closes the stream
		status_t     status;  // shared by all results of the group
		logic [1:0]  cnt;     // number of results, 0..3
		logic [23:0] bytes;   // first result in the top byte
	} res_grp_t;

	// Alphabet lookup: {valid, sixtet}
	function automatic logic [6:0] to_sixtet(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c inside {[8'h41:8'h5a]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7a]}) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2b) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2f) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ===== hdl/b64d_step.sv =====
// Per-character decode step: stream state registers and the result group
// one character causes. Depends on b64d_pkg.

module b64d_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            pad_char,
	input  logic [7:0]            char_in,
	input  logic                  last_char,
	input  logic                  adv,
	output b64d_pkg::res_grp_t    grp
);

	b64d_pkg::dec_state_t st_q;
	b64d_pkg::dec_state_t st_d;

	logic [6:0]  sx;
	logic [5:0]  s;
	logic        valid;
	logic        is_pad;
	logic        pad_en;
	logic [17:0] gb_sh;
	logic [17:0] gb_ins;
	logic [17:0] gb_new;
	logic [1:0]  pads_n;
	logic        err;
	logic        part;
	b64d_pkg::status_t code;

	assign sx     = b64d_pkg::to_sixtet(char_in);
	assign valid  = sx[6];
	assign s      = sx[5:0];
	assign pad_en = pad_char != 8'd0;
	assign is_pad = pad_en && (char_in == pad_char);
	assign gb_sh  = {st_q.gbits[11:0], 6'd0};
	assign gb_ins = {st_q.gbits[11:0], s};

	// Next state and result group
	always_comb begin
		st_d   = st_q;
		grp    = '0;
		grp.status = b64d_pkg::ST_OK;
		err    = 1'b0;
		part   = 1'b0;
		code   = b64d_pkg::ST_OK;
		gb_new = gb_ins;
		pads_n = st_q.pads;
		if (st_q.failed) begin
			if (last_char) begin
				st_d = '0;
			end
		end else if (st_q.pdone) begin
			err  = 1'b1;
			code = b64d_pkg::ST_AFTER_GROUP;
		end else begin
			case (st_q.pos)
				2'd0, 2'd1: begin
					if (!valid) begin
						err  = 1'b1;
						code = is_pad ? b64d_pkg::ST_MISPLACED : b64d_pkg::ST_INVALID;
					end else begin
						st_d.gbits = gb_ins;
						part = 1'b1;
					end
				end
				2'd2: begin
					if (is_pad) begin
						gb_new     = gb_sh;
						st_d.gbits = gb_sh;
						st_d.pads  = 2'd1;
						part = 1'b1;
					end else if (valid) begin
						st_d.gbits = gb_ins;
						part = 1'b1;
					end else begin
						err  = 1'b1;
						code = b64d_pkg::ST_INVALID;
					end
				end
				default: begin
					// fourth character closes the group
					if (is_pad) begin
						pads_n = st_q.pads + 2'd1;
					end else if (st_q.pads != 2'd0) begin
						err  = 1'b1;
						code = b64d_pkg::ST_DATA_AFTER;
					end else if (!valid) begin
						err  = 1'b1;
						code = b64d_pkg::ST_INVALID;
					end
					if (!err) begin
						grp.cnt   = 2'd3 - pads_n;
						grp.bytes = {st_q.gbits, is_pad ? 6'd0 : s};
						grp.eos   = last_char;
						st_d       = '0;
						st_d.pdone = (pads_n != 2'd0) && !last_char;
					end
				end
			endcase
			// end mark inside a group
			if (part) begin
				st_d.pos = st_q.pos + 2'd1;
				if (last_char) begin
					st_d = '0;
					if (pad_en || st_q.pos == 2'd0) begin
						err  = 1'b1;
						code = b64d_pkg::ST_TRUNCATED;
					end else if (st_q.pos == 2'd1) begin
						grp.cnt   = 2'd1;
						grp.bytes = {gb_new[11:4], 16'd0};
						grp.eos   = 1'b1;
					end else begin
						grp.cnt   = 2'd2;
						grp.bytes = {gb_new[17:10], gb_new[9:2], 8'd0};
						grp.eos   = 1'b1;
					end
				end
			end
		end
		// single error result, then drop until end mark
		if (err) begin
			grp.cnt    = 2'd1;
			grp.bytes  = '0;
			grp.status = code;
			grp.eos    = last_char;
			st_d        = '0;
			st_d.failed = !last_char;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_d;
		end
	end

endmodule

// ===== hdl/b64d_emit.sv =====
// Result register: holds one result group and hands it out one byte per
// transfer. Depends on b64d_pkg.

module b64d_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  b64d_pkg::res_grp_t    grp_in,
	output logic                  free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,
	output logic [3:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	b64d_pkg::res_grp_t grp_q;
	logic               vld_q;
	logic [1:0]         idx_q;
	logic               take;
	logic               fin;

	assign fin  = idx_q == (grp_q.cnt - 2'd1);
	assign take = vld_q && m_axis_tready;
	assign free = !vld_q || (take && fin);

	// Byte select for the current result
	always_comb begin
		case (idx_q)
			2'd0:    m_axis_tdata = grp_q.bytes[23:16];
			2'd1:    m_axis_tdata = grp_q.bytes[15:8];
			default: m_axis_tdata = grp_q.bytes[7:0];
		endcase
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tlast  = fin;
	assign m_axis_tuser  = {fin && grp_q.eos, grp_q.status};

	// Control: valid flag and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (take) begin
			if (fin) begin
				vld_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_in;
		end
	end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder: input stage, decode step and
// result register. Depends on b64d_pkg, b64d_step and b64d_emit.
//
//  channel   dir  tdata                   tuser                        tlast
//  s_axis    in   [7:0] char_in           -                            last_char
//  m_axis    out  [7:0] data_byte         [2:0] status, [3] end_of_stream  last_of_run
//  pad_char  in   pad_char_wdata on pad_char_we (write only)
//
// A character passes the input register and the result register before its first
// result. The input register takes one character per cycle while the decode step
// advances; a character with three results holds the output for three transfers,
// so the sustained rate is set by the result register draining one byte per cycle
// while m_axis is ready. Characters with no result pass through without waiting
// on the output. Reset clears all stream state and sets the padding character to
// '='. Stalls on m_axis propagate back to s_axis tready through the input register.

module base64_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pad_char_we,
	input  logic [7:0] pad_char_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic [3:0] m_axis_tuser,   // [2:0] status, [3] end_of_stream
	output logic       m_axis_tlast
);

	logic [7:0]         pad_char_q;
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               last_s1;
	logic               adv;
	logic               free;
	b64d_pkg::res_grp_t grp;

	// Padding character register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_char_q <= b64d_pkg::PAD_RESET;
		end else if (pad_char_we) begin
			pad_char_q <= pad_char_wdata;
		end
	end

	// Input stage
	assign adv           = valid_s1 && (grp.cnt == 2'd0 || free);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	b64d_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.pad_char  (pad_char_q),
		.char_in   (char_s1),
		.last_char (last_s1),
		.adv       (adv),
		.grp       (grp)
	);

	b64d_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && grp.cnt != 2'd0),
		.grp_in        (grp),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Error results are single, zero-data and close their run
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != b64d_pkg::ST_OK
		|-> m_axis_tlast && m_axis_tdata == 8'd0)
		else $error("error result not a single zero byte");

	// End of stream only on the final result of a run
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast)
		else $error("end_of_stream without last_of_run");

	// Status stays within the defined codes
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] <= b64d_pkg::ST_AFTER_GROUP)
		else $error("undefined status code");

	// Input stalls only while the input stage holds a character
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid)
		else $error("input stalled with nothing pending");

endmodule
